### rtl/assert_macros.svh
// Assertion helper macros used by dae_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check under the module reset
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication check under the module reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/dae_pkg.sv
// ----------------------------------------------------------------------------
// dae_pkg
// Types, constants and the step table of the decimating ADPCM encoder.
// ----------------------------------------------------------------------------
package dae_pkg;

    localparam int unsigned OUTPUT_RATE = 8000;
    localparam int unsigned MAX_RATE    = 192000;
    localparam logic [6:0]  STEP_TOP    = 7'd66;
    localparam logic [6:0]  STEP_START  = 7'd40;

    localparam logic [0:0] CFG_RATE     = 1'b0;
    localparam logic [0:0] CFG_CHANNELS = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic restart;   // clear stream state
        logic add;       // accumulate the accepted frame
        logic div_start; // load the divider
        logic div_step;  // one quotient bit
        logic code;      // code the average and pack
        logic flush;     // last frame: restart after capture
        logic load_out;  // capture result
    } dae_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic window_done;
        logic div_done;
        logic byte_full;
    } dae_stat_t;

    function automatic logic [14:0] step_lookup(input logic [6:0] idx);
        logic [14:0] s;
        unique case (idx)
            7'd0: s = 15'd16;      7'd1: s = 15'd18;      7'd2: s = 15'd20;
            7'd3: s = 15'd22;      7'd4: s = 15'd25;      7'd5: s = 15'd28;
            7'd6: s = 15'd31;      7'd7: s = 15'd35;      7'd8: s = 15'd39;
            7'd9: s = 15'd44;      7'd10: s = 15'd49;     7'd11: s = 15'd55;
            7'd12: s = 15'd62;     7'd13: s = 15'd69;     7'd14: s = 15'd78;
            7'd15: s = 15'd87;     7'd16: s = 15'd98;     7'd17: s = 15'd110;
            7'd18: s = 15'd123;    7'd19: s = 15'd138;    7'd20: s = 15'd155;
            7'd21: s = 15'd174;    7'd22: s = 15'd195;    7'd23: s = 15'd219;
            7'd24: s = 15'd246;    7'd25: s = 15'd276;    7'd26: s = 15'd310;
            7'd27: s = 15'd348;    7'd28: s = 15'd391;    7'd29: s = 15'd439;
            7'd30: s = 15'd493;    7'd31: s = 15'd553;    7'd32: s = 15'd621;
            7'd33: s = 15'd697;    7'd34: s = 15'd782;    7'd35: s = 15'd878;
            7'd36: s = 15'd986;    7'd37: s = 15'd1107;   7'd38: s = 15'd1243;
            7'd39: s = 15'd1395;   7'd40: s = 15'd1566;   7'd41: s = 15'd1758;
            7'd42: s = 15'd1973;   7'd43: s = 15'd2215;   7'd44: s = 15'd2486;
            7'd45: s = 15'd2790;   7'd46: s = 15'd3132;   7'd47: s = 15'd3516;
            7'd48: s = 15'd3947;   7'd49: s = 15'd4431;   7'd50: s = 15'd4975;
            7'd51: s = 15'd5585;   7'd52: s = 15'd6270;   7'd53: s = 15'd7040;
            7'd54: s = 15'd7904;   7'd55: s = 15'd8874;   7'd56: s = 15'd9963;
            7'd57: s = 15'd11188;  7'd58: s = 15'd12561;  7'd59: s = 15'd14102;
            7'd60: s = 15'd15836;  7'd61: s = 15'd17783;  7'd62: s = 15'd19970;
            7'd63: s = 15'd22426;  7'd64: s = 15'd25184;  7'd65: s = 15'd28281;
            default: s = 15'd31759;
        endcase
        return s;
    endfunction

endpackage

### rtl/dae_ctrl.sv
// ----------------------------------------------------------------------------
// dae_ctrl
// Sequencer: accepts a frame; per window, runs the serial divide and codes; emits results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dae_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_last,
    input  logic              cfg_write,
    input  logic              out_busy,
    input  logic              out_fire,
    input  dae_pkg::dae_stat_t stat,
    output dae_pkg::dae_cmd_t  cmd,
    output logic              in_ready
);
    import dae_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHK  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_CODE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       last_reg, last_next;

    assign in_ready = (state_reg == ST_IDLE) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.restart = cfg_write;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.add    = 1'b1;
                    last_next  = in_last;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (stat.window_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    if (last_reg)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.flush    = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_CODE;
                end
            end
            default:
            begin
                cmd.code = 1'b1;
                if (stat.byte_full || last_reg)
                begin
                    cmd.load_out = 1'b1;
                end
                cmd.flush  = last_reg;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    `ASSERT_IMPLY(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_fire_chk, clk, rst_n, in_fire, state_reg == ST_CHK)
    `ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.load_out, !out_busy || out_fire)
endmodule

### rtl/dae_dp.sv
// ----------------------------------------------------------------------------
// dae_dp
// Datapath: window accumulator, serial divider, coder, byte packer.
// ----------------------------------------------------------------------------
module dae_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  dae_pkg::dae_cmd_t  cmd,
    input  logic [17:0]       rate_cfg,
    input  logic [1:0]        chan_cfg,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    output dae_pkg::dae_stat_t stat,
    output logic [7:0]        res_byte,
    output logic [2:0]        res_count
);
    import dae_pkg::*;

    localparam int unsigned RW = 18;
    localparam logic [RW-1:0] OUT_R = RW'(OUTPUT_RATE);
    localparam logic [RW-1:0] MAX_R = RW'(MAX_RATE);
    // 8000 = 64 * 125: drop the 64 by a shift, then multiply by ceil(2^19 / 125)
    localparam logic [12:0] RECIP_125 = 13'd4195;

    logic [RW-1:0] rate_u;
    logic [11:0]   rate_q64;
    logic [24:0]   recip_prod;
    logic [RW-1:0] base_len, rem;
    always_comb
    begin
        rate_u = rate_cfg;
        if (rate_u < OUT_R) rate_u = OUT_R;
        if (rate_u > MAX_R) rate_u = MAX_R;
        rate_q64   = rate_u[17:6];
        recip_prod = 25'(rate_q64) * 25'(RECIP_125);
        base_len   = RW'(recip_prod[23:19]);
        rem        = rate_u - base_len * OUT_R;
    end

    logic signed [15:0] pred_reg;
    logic [6:0]  idx_reg;
    logic signed [21:0] sum_reg;
    logic [5:0]  cnt_reg;
    logic [RW-1:0] frames_reg, acc_reg;
    logic [7:0]  pend_reg;
    logic [1:0]  pcnt_reg;
    logic [7:0]  obyte_reg;
    logic [2:0]  ocnt_reg;
    // divider
    logic [21:0] dq_reg;
    logic [6:0]  drem_reg;
    logic [4:0]  dstep_reg;
    logic        dneg_reg;
    logic signed [15:0] avg_reg;

    logic stereo;
    assign stereo = (chan_cfg == 2'd2);

    function automatic logic [RW-1:0] len_for(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b,
                                              input logic [RW-1:0] r);
        logic [RW:0] t;
        t = {1'b0, a} + {1'b0, r};
        return b + ((t >= {1'b0, OUT_R}) ? RW'(1) : RW'(0));
    endfunction

    logic [RW-1:0] frames_inc;
    logic [RW-1:0] len_cur;
    assign frames_inc = frames_reg;
    assign len_cur    = len_for(acc_reg, base_len, rem);
    assign stat.window_done = (frames_reg >= len_cur);
    assign stat.div_done    = (dstep_reg == 5'd22);
    assign stat.byte_full   = (pcnt_reg == 2'd3);

    // coder
    logic [14:0] step;
    logic signed [17:0] diff, p;
    logic [16:0] adiff;
    logic        mag, neg;
    logic [14:0] delta;
    logic signed [7:0] nidx;
    logic [1:0]  code;
    logic [RW:0] acc_sum;
    logic [RW-1:0] acc_new;
    logic [7:0]  pend_new;
    always_comb
    begin
        step  = step_lookup((idx_reg > STEP_TOP) ? STEP_TOP : idx_reg);
        diff  = 18'(avg_reg) - 18'(pred_reg);
        neg   = diff[17];
        adiff = neg ? 17'(-diff) : 17'(diff);
        mag   = (adiff >= 17'(step >> 1));
        delta = 15'(step >> 2) + (mag ? 15'(step >> 1) : 15'd0);
        p     = neg ? 18'(pred_reg) - 18'(delta) : 18'(pred_reg) + 18'(delta);
        if (p < -18'sd32768) p = -18'sd32768;
        if (p > 18'sd32767) p = 18'sd32767;
        nidx  = $signed({1'b0, idx_reg}) + (mag ? 8'sd2 : -8'sd1);
        if (nidx < 0) nidx = 8'sd0;
        if (nidx > $signed({1'b0, STEP_TOP})) nidx = $signed({1'b0, STEP_TOP});
        code  = {neg, mag};
        acc_sum = {1'b0, acc_reg} + {1'b0, rem};
        acc_new = (acc_sum >= {1'b0, OUT_R}) ? RW'(acc_sum - {1'b0, OUT_R})
                                             : acc_sum[RW-1:0];
        pend_new = pend_reg | (8'(code) << {pcnt_reg, 1'b0});
    end

    logic [6:0] shifted;
    logic       trial;
    assign shifted = {drem_reg[5:0], dq_reg[21]};
    assign trial   = shifted >= 7'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg   <= '0;
            idx_reg    <= STEP_START;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            frames_reg <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            pcnt_reg   <= '0;
            dstep_reg  <= '0;
            dq_reg     <= '0;
            drem_reg   <= '0;
            dneg_reg   <= 1'b0;
            avg_reg    <= '0;
        end
        else if (cmd.restart || cmd.flush)
        begin
            pred_reg   <= '0;
            idx_reg    <= STEP_START;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            frames_reg <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            pcnt_reg   <= '0;
        end
        else
        begin
            if (cmd.add)
            begin
                sum_reg <= sum_reg + 22'(left_sample)
                           + (stereo ? 22'(right_sample) : 22'sd0);
                cnt_reg <= cnt_reg + (stereo ? 6'd2 : 6'd1);
                frames_reg <= frames_inc + RW'(1);
            end
            if (cmd.div_start)
            begin
                dneg_reg  <= sum_reg[21];
                dq_reg    <= sum_reg[21] ? 22'(-sum_reg) : 22'(sum_reg);
                drem_reg  <= '0;
                dstep_reg <= '0;
            end
            if (cmd.div_step && !stat.div_done)
            begin
                drem_reg  <= trial ? shifted - 7'(cnt_reg) : shifted;
                dq_reg    <= {dq_reg[20:0], trial};
                dstep_reg <= dstep_reg + 5'd1;
            end
            if (cmd.div_step && stat.div_done)
            begin
                avg_reg <= dneg_reg ? 16'(-dq_reg) : 16'(dq_reg);
            end
            if (cmd.code)
            begin
                pred_reg   <= 16'(p);
                idx_reg    <= 7'(nidx);
                sum_reg    <= '0;
                cnt_reg    <= '0;
                frames_reg <= '0;
                acc_reg    <= acc_new;
                pend_reg   <= stat.byte_full ? 8'd0 : pend_new;
                pcnt_reg   <= pcnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.code)
            begin
                obyte_reg <= pend_new;
                ocnt_reg  <= 3'(pcnt_reg) + 3'd1;
            end
            else
            begin
                obyte_reg <= pend_reg;
                ocnt_reg  <= 3'(pcnt_reg);
            end
        end
    end

    assign res_byte  = obyte_reg;
    assign res_count = ocnt_reg;
endmodule

### rtl/decimating_adpcm2_encoder.sv
// ----------------------------------------------------------------------------
// decimating_adpcm2_encoder
// Box-average PCM down to the output rate and pack 2-bit ADPCM codes.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one PCM frame per request;
// right_sample is used only when channel_count is 2. Output channel
// out_valid/out_ready carries one packed byte per request: code_byte,
// codes_in_byte and stream_end.
// One frame is taken at a time. A frame that does not close a window only
// passes the check state; one that closes a window then runs the bit-serial
// divider for the window average, then codes and packs the sample.
// A result shows in the cycle after its frame finishes and sits in the output
// register; a new frame is not taken while that register is full and not
// being drained, so a stalled receiver holds the input side.
// Reset sets input_rate to 8000, channel_count to 1 and clears the stream.
// A configuration write restarts the stream and drops pending codes; write
// only while idle. last_frame flushes a padded partial byte with stream_end.
// ----------------------------------------------------------------------------
module decimating_adpcm2_encoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [0:0]        cfg_index,
    input  logic [17:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic              last_frame,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        code_byte,
    output logic [2:0]        codes_in_byte,
    output logic              stream_end
);
    import dae_pkg::*;

    logic [17:0] rate_reg;
    logic [1:0]  chan_reg;
    logic        ov_reg, end_reg;
    dae_cmd_t    cmd;
    dae_stat_t   stat;
    logic        in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 18'd8000;
            chan_reg <= 2'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RATE:     rate_reg <= cfg_data;
                CFG_CHANNELS: chan_reg <= cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            end_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            ov_reg  <= 1'b1;
            end_reg <= cmd.flush;
        end
        else if (out_fire)
        begin
            ov_reg <= 1'b0;
        end
    end

    dae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_last  (last_frame),
        .cfg_write(cfg_write),
        .out_busy (ov_reg && !out_ready),
        .out_fire (out_fire),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    dae_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rate_cfg    (rate_reg),
        .chan_cfg    (chan_reg),
        .left_sample (left_sample),
        .right_sample(right_sample),
        .stat        (stat),
        .res_byte    (code_byte),
        .res_count   (codes_in_byte)
    );

    assign out_valid  = ov_reg;
    assign stream_end = end_reg;
endmodule
